@@ design/cartridge_bank_controller_assert.svh @@
// Assertion macros used by the cartridge bank controller datapath.
`ifndef CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH
`define CARTRIDGE_BANK_CONTROLLER_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cartridge bank controller check failed");

// The expression must never be true.
`define CBC_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("cartridge bank controller check failed");

`endif

@@ design/cbc_pkg.sv @@
// Shared types and constants of the cartridge bank controller.
`timescale 1ns / 1ps
package cbc_pkg;

	// Field widths.
	localparam int ADDR_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int ROM_ADDR_W = 21;
	localparam int BANK_W     = 7;
	localparam int LOW_BANK_W = 5;
	localparam int OFFSET_W   = 14;
	localparam int RAM_OFS_W  = 13;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd1;
	localparam logic [1:0] CFG_MULTICART      = 2'd2;

	// Control register regions, address bits 14:13 below 0x8000.
	localparam logic [1:0] REG_RAM_ENABLE = 2'b00;
	localparam logic [1:0] REG_ROM_BANK   = 2'b01;
	localparam logic [1:0] REG_UPPER_BANK = 2'b10;
	localparam logic [1:0] REG_MODE       = 2'b11;

	// Address bits 15:13 of the RAM window.
	localparam logic [2:0] RAM_WINDOW = 3'b101;

	// Low nibble that enables RAM.
	localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

	// Access kinds.
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic clear;
		logic load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic rom_rd;
		logic ram_rd;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

@@ design/cbc_ctrl.sv @@
// Controller state machine of the cartridge bank controller.
`timescale 1ns / 1ps
module cbc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  cbc_pkg::status_t st,
	output cbc_pkg::cmd_t    cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DEC   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.clear   = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.exec = 1'b1;
				if (st.rom_rd) begin
					state_d = ST_DIV;
				end else if (st.ram_rd) begin
					state_d = ST_LOAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (!st.div_busy) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the RAM clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

@@ design/cbc_datapath.sv @@
// Datapath of the cartridge bank controller: registers, bank mapping, remainder unit, RAM.
`timescale 1ns / 1ps
`include "cartridge_bank_controller_assert.svh"
module cbc_datapath #(
	parameter int MAX_RAM_BANKS = 4,
	parameter int ROM_ADDR_BITS = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cbc_pkg::cmd_t    cmd,
	output cbc_pkg::status_t st,
	input  logic [23:0]      s_tdata,
	input  logic             s_tuser,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,
	output logic             m_tuser
);

	localparam int RAM_AW    = cbc_pkg::RAM_OFS_W + $clog2(MAX_RAM_BANKS);
	localparam int RAM_DEPTH = MAX_RAM_BANKS * 8192;
	localparam logic [cbc_pkg::ROM_ADDR_W-1:0] ROM_MASK =
		cbc_pkg::ROM_ADDR_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);
	localparam logic [2:0] MAX_BANKS = 3'(MAX_RAM_BANKS);

	// Configuration registers.
	logic [7:0] rom_bank_count_q;
	logic [2:0] ram_bank_count_q;
	logic       multicart_q;

	// Bank control registers.
	logic                          ram_en_q;
	logic [cbc_pkg::LOW_BANK_W-1:0] rom_sel_q;
	logic [1:0]                    upper_q;
	logic                          mode_q;

	// Captured item.
	logic                        kind_q;
	logic [cbc_pkg::ADDR_W-1:0]  addr_q;
	logic [cbc_pkg::BYTE_W-1:0]  wdata_q;

	// Remainder unit.
	logic                        div_busy_q;
	logic [2:0]                  div_cnt_q;
	logic [cbc_pkg::BANK_W-1:0]  dvd_q;
	logic [cbc_pkg::BANK_W-1:0]  bank_raw_q;
	logic [7:0]                  rem_q;
	logic [8:0]                  trial;

	// RAM and clearing pass.
	logic [cbc_pkg::BYTE_W-1:0] mem [RAM_DEPTH];
	logic [RAM_AW-1:0]          clr_cnt_q;
	logic [cbc_pkg::BYTE_W-1:0] ram_rdata_q;
	logic                       mem_we;
	logic                       mem_re;
	logic [RAM_AW-1:0]          mem_addr;
	logic [cbc_pkg::BYTE_W-1:0] mem_wdata;

	// Output register.
	logic                           out_valid_q;
	logic                           out_rom_q;
	logic [cbc_pkg::ROM_ADDR_W-1:0] out_addr_q;
	logic [cbc_pkg::BYTE_W-1:0]     out_data_q;

	// Decode of the captured item.
	logic in_ram;
	logic reg_wr;
	logic ram_wr;
	logic [cbc_pkg::LOW_BANK_W-1:0] low_bank;
	logic [cbc_pkg::BANK_W-1:0]     bank_raw;
	logic [2:0]                     ram_cnt;
	logic [1:0]                     ram_bank;
	logic [14:0]                    ram_idx_full;
	logic [cbc_pkg::BANK_W-1:0]     bank_final;
	logic [cbc_pkg::ROM_ADDR_W-1:0] rom_addr;

	assign in_ram = (addr_q[15:13] == cbc_pkg::RAM_WINDOW);
	assign reg_wr = (kind_q == cbc_pkg::KIND_WRITE) && !addr_q[15];
	assign ram_wr = (kind_q == cbc_pkg::KIND_WRITE) && in_ram && ram_en_q;

	assign st.rom_rd     = (kind_q == cbc_pkg::KIND_READ) && !addr_q[15];
	assign st.ram_rd     = (kind_q == cbc_pkg::KIND_READ) && in_ram;
	assign st.div_busy   = div_busy_q;
	assign st.out_free   = !out_valid_q || m_tready;
	assign st.clear_last = (clr_cnt_q == RAM_AW'(RAM_DEPTH - 1));

	// Unwrapped bank of the addressed ROM window.
	always_comb begin
		low_bank = (rom_sel_q == '0) ? cbc_pkg::LOW_BANK_W'(1) : rom_sel_q;
		if (!addr_q[14]) begin
			if (!mode_q) begin
				bank_raw = '0;
			end else if (multicart_q) begin
				bank_raw = {1'b0, upper_q, 4'b0000};
			end else begin
				bank_raw = {upper_q, 5'b00000};
			end
		end else if (multicart_q) begin
			bank_raw = {1'b0, upper_q, low_bank[3:0]};
		end else begin
			bank_raw = {upper_q, low_bank};
		end
	end

	// RAM bank: upper bits modulo the clamped RAM bank count, bank 0 when the mode bit is clear.
	always_comb begin
		if (ram_bank_count_q == 3'd0) begin
			ram_cnt = 3'd1;
		end else if (ram_bank_count_q > MAX_BANKS) begin
			ram_cnt = MAX_BANKS;
		end else begin
			ram_cnt = ram_bank_count_q;
		end
		case (ram_cnt)
			3'd1:    ram_bank = 2'd0;
			3'd2:    ram_bank = {1'b0, upper_q[0]};
			3'd3:    ram_bank = (upper_q == 2'd3) ? 2'd0 : upper_q;
			default: ram_bank = upper_q;
		endcase
		if (!mode_q) begin
			ram_bank = 2'd0;
		end
		ram_idx_full = {ram_bank, addr_q[cbc_pkg::RAM_OFS_W-1:0]};
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q <= 8'd2;
			ram_bank_count_q <= 3'd1;
			multicart_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_q <= cfg_data;
				cbc_pkg::CFG_RAM_BANK_COUNT: ram_bank_count_q <= cfg_data[2:0];
				cbc_pkg::CFG_MULTICART:      multicart_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Bank control register writes from the bus.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q  <= 1'b0;
			rom_sel_q <= cbc_pkg::LOW_BANK_W'(1);
			upper_q   <= 2'd0;
			mode_q    <= 1'b0;
		end else if (cmd.exec && reg_wr) begin
			case (addr_q[14:13])
				cbc_pkg::REG_RAM_ENABLE: ram_en_q  <= (wdata_q[3:0] == cbc_pkg::RAM_ENABLE_KEY);
				cbc_pkg::REG_ROM_BANK:   rom_sel_q <= wdata_q[cbc_pkg::LOW_BANK_W-1:0];
				cbc_pkg::REG_UPPER_BANK: upper_q   <= wdata_q[1:0];
				cbc_pkg::REG_MODE:       mode_q    <= wdata_q[0];
				default: ;
			endcase
		end
	end

	// Item capture on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= s_tuser;
			addr_q  <= s_tdata[15:0];
			wdata_q <= s_tdata[23:16];
		end
	end

	// Bit-serial remainder of the ROM bank by the ROM bank count.
	assign trial = {rem_q, dvd_q[cbc_pkg::BANK_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= 3'd0;
		end else if (cmd.exec && st.rom_rd) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= 3'(cbc_pkg::BANK_W);
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 3'd1;
			if (div_cnt_q == 3'd1) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && st.rom_rd) begin
			rem_q      <= 8'd0;
			dvd_q      <= bank_raw;
			bank_raw_q <= bank_raw;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[cbc_pkg::BANK_W-2:0], 1'b0};
			if (trial >= {1'b0, rom_bank_count_q}) begin
				rem_q <= 8'(trial - {1'b0, rom_bank_count_q});
			end else begin
				rem_q <= trial[7:0];
			end
		end
	end

	// Physical ROM address; a zero bank count applies no wrap.
	assign bank_final = (rom_bank_count_q == 8'd0) ? bank_raw_q : rem_q[cbc_pkg::BANK_W-1:0];
	assign rom_addr   = {bank_final, addr_q[cbc_pkg::OFFSET_W-1:0]} & ROM_MASK;

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + RAM_AW'(1);
		end
	end

	// Cartridge RAM, one port.
	assign mem_we    = cmd.clear || (cmd.exec && ram_wr);
	assign mem_re    = cmd.exec && st.ram_rd;
	assign mem_addr  = cmd.clear ? clr_cnt_q : ram_idx_full[RAM_AW-1:0];
	assign mem_wdata = cmd.clear ? 8'hFF : wdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			ram_rdata_q <= mem[mem_addr];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_rom_q  <= st.rom_rd;
			out_addr_q <= st.rom_rd ? rom_addr : '0;
			out_data_q <= st.rom_rd ? 8'd0 : ram_rdata_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_rom_q;
	assign m_tdata  = {3'b000, out_data_q, out_addr_q};

	// A new result never overwrites one that has not been taken.
	`CBC_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load, st.out_free)
	// Bus accesses never touch the RAM port during the clearing pass.
	`CBC_ASSERT_NEVER(a_clear_excl, clk, arst_n, cmd.clear && (cmd.exec || cmd.capture))
	// The remainder ends below the bank count.
	`CBC_ASSERT_IMP(a_rem_range, clk, arst_n,
		$fell(div_busy_q) && (rom_bank_count_q != 8'd0), rem_q < rom_bank_count_q)

endmodule

@@ design/cartridge_bank_controller.sv @@
// Top level of the cartridge bank controller: controller and datapath.
// ROM read: captured, decoded, run through the bit-serial remainder unit (one bank bit
// per cycle, 7 bits), then loaded once the output register is free. RAM read: decoded
// with a registered RAM read, then loaded; a write ends at decode. A new item is taken
// only after the last is done. After reset a clearing pass fills 8192 * MAX_RAM_BANKS
// RAM bytes with 0xFF, taking no input; configuration writes are taken throughout.
`timescale 1ns / 1ps
module cartridge_bank_controller #(
	parameter int MAX_RAM_BANKS = 4,
	parameter int ROM_ADDR_BITS = 21
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input item.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // bus_address[15:0], write_data[23:16]
	input  logic        s_tuser,  // kind
	// Result item.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // rom_byte_address[20:0], read_data[28:21], zero fill
	output logic        m_tuser,  // from_rom
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cbc_pkg::cmd_t    cmd;
	cbc_pkg::status_t st;

	cbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cbc_datapath #(
		.MAX_RAM_BANKS (MAX_RAM_BANKS),
		.ROM_ADDR_BITS (ROM_ADDR_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
